@@ hw/rtl/dfm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfm_pkg
// shared constants and dpd coding functions for the decimal32 remainder block
// ----------------------------------------------------------------------------
package dfm_pkg;

    localparam int CoefW = 24;
    localparam int ModW  = 27;
    localparam int BcdW  = 28;
    localparam logic [31:0] QNAN_BITS = 32'h7C00_0000;
    localparam logic [7:0]  EXP_BIAS  = 8'd101;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CHECK  = 8'b0000_0010,
        S_ALIGN  = 8'b0000_0100,
        S_SCALE  = 8'b0000_1000,
        S_MODX   = 8'b0001_0000,
        S_DIGIT  = 8'b0010_0000,
        S_CONV   = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic [ModW-1:0] opa;
        logic [ModW-1:0] opb;
        logic            cin;
        logic [ModW-1:0] modulus;
    } unit_op_t;

    // declet to three bcd digits
    function automatic logic [11:0] dpd_decode(input logic [9:0] b);
        logic p, q, r, s, t, u, v, w, x, y;
        logic [3:0] d2, d1, d0;
        p = b[9]; q = b[8]; r = b[7]; s = b[6]; t = b[5];
        u = b[4]; v = b[3]; w = b[2]; x = b[1]; y = b[0];
        d2 = {1'b0, p, q, r};
        d1 = {1'b0, s, t, u};
        d0 = {1'b0, w, x, y};
        if (v)
        begin
            case ({w, x})
                2'd0:
                begin
                    d0 = {3'b100, y};
                end
                2'd1:
                begin
                    d1 = {3'b100, u};
                    d0 = {1'b0, s, t, y};
                end
                2'd2:
                begin
                    d2 = {3'b100, r};
                    d0 = {1'b0, p, q, y};
                end
                default:
                begin
                    case ({s, t})
                        2'd0:
                        begin
                            d2 = {3'b100, r};
                            d1 = {3'b100, u};
                            d0 = {1'b0, p, q, y};
                        end
                        2'd1:
                        begin
                            d2 = {3'b100, r};
                            d1 = {1'b0, p, q, u};
                            d0 = {3'b100, y};
                        end
                        2'd2:
                        begin
                            d1 = {3'b100, u};
                            d0 = {3'b100, y};
                        end
                        default:
                        begin
                            d2 = {3'b100, r};
                            d1 = {3'b100, u};
                            d0 = {3'b100, y};
                        end
                    endcase
                end
            endcase
        end
        return {d2, d1, d0};
    endfunction

    function automatic logic [9:0] bcd3_to_bin(input logic [11:0] d);
        return 10'(d[11:8]) * 10'd100 + 10'(d[7:4]) * 10'd10 + 10'(d[3:0]);
    endfunction

    // three bcd digits to canonical declet
    function automatic logic [9:0] dpd_encode(input logic [11:0] d);
        logic [3:0] d2, d1, d0;
        logic [9:0] e;
        d2 = d[11:8]; d1 = d[7:4]; d0 = d[3:0];
        case ({d2[3], d1[3], d0[3]})
            3'd0: e = {d2[2:0], d1[2:0], 1'b0, d0[2:0]};
            3'd1: e = {d2[2:0], d1[2:0], 3'b100, d0[0]};
            3'd2: e = {d2[2:0], d0[2:1], d1[0], 3'b101, d0[0]};
            3'd4: e = {d0[2:1], d2[0], d1[2:0], 3'b110, d0[0]};
            3'd6: e = {d0[2:1], d2[0], 2'b00, d1[0], 3'b111, d0[0]};
            3'd5: e = {d1[2:1], d2[0], 2'b01, d1[0], 3'b111, d0[0]};
            3'd3: e = {d2[2:0], 2'b10, d1[0], 3'b111, d0[0]};
            default: e = {2'b00, d2[0], 2'b11, d1[0], 3'b111, d0[0]};
        endcase
        return e;
    endfunction

    function automatic logic [31:0] pack(input logic sign, input logic [BcdW-1:0] bcd,
                                         input logic [7:0] be);
        logic [4:0] comb;
        if (!bcd[27])
            comb = {be[7:6], bcd[26:24]};
        else
            comb = {2'b11, be[7:6], bcd[24]};
        return {sign, comb, be[5:0], dpd_encode(bcd[23:12]), dpd_encode(bcd[11:0])};
    endfunction

    function automatic logic [2:0] digit_count(input logic [CoefW-1:0] c);
        logic [2:0] n;
        n = 3'd1;
        if (c >= 24'd10)      n = 3'd2;
        if (c >= 24'd100)     n = 3'd3;
        if (c >= 24'd1000)    n = 3'd4;
        if (c >= 24'd10000)   n = 3'd5;
        if (c >= 24'd100000)  n = 3'd6;
        if (c >= 24'd1000000) n = 3'd7;
        return n;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/dfm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfm channel interfaces
// operand request channel and remainder response channel
// ----------------------------------------------------------------------------
interface dfm_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] dividend_bits;
    logic [31:0] divisor_bits;
    modport source (output valid, dividend_bits, divisor_bits, input ready);
    modport sink   (input valid, dividend_bits, divisor_bits, output ready);
endinterface

interface dfm_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] remainder_bits;
    logic        domain_error;
    modport source (output valid, remainder_bits, domain_error, input ready);
    modport sink   (input valid, remainder_bits, domain_error, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/dfm_mod_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfm_mod_unit
// shared modular adder: (opa + opb + cin) reduced once by the modulus
// ----------------------------------------------------------------------------
module dfm_mod_unit (
    input  var dfm_pkg::unit_op_t        op,
    output logic [dfm_pkg::ModW-1:0]     res
);
    logic [dfm_pkg::ModW:0] sum;
    logic [dfm_pkg::ModW:0] diff;

    assign sum  = {1'b0, op.opa} + {1'b0, op.opb} + {{dfm_pkg::ModW{1'b0}}, op.cin};
    assign diff = sum - {1'b0, op.modulus};
    assign res  = (sum >= {1'b0, op.modulus}) ? diff[dfm_pkg::ModW-1:0]
                                               : sum[dfm_pkg::ModW-1:0];
endmodule
`default_nettype wire

@@ hw/rtl/decimal32_fmod_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal32_fmod_top
// decimal32 (dpd) remainder x fmod y with the sign of x, exact
// ----------------------------------------------------------------------------
// req carries dividend_bits and divisor_bits; rsp returns remainder_bits and
// domain_error (quiet nan 0x7C000000 for inf/nan operands or zero divisor).
// one request at a time: req.ready is high only while the sequencer is idle.
// steps: special cases and |x| <= |y| finish from the check and align
// states; otherwise divisor scaling (when x has the smaller exponent),
// binary long division on the coefficient, a multiply by ten modulo the
// divisor per unit of exponent difference (up to 191) on the shared
// modular adder, and binary to bcd conversion.
// the result sits in an output register; a new request is taken while it
// waits, and the sequencer holds its next result until rsp is free.
// reset (rst_n low, asynchronous) returns to idle with no result pending.
// ----------------------------------------------------------------------------
module decimal32_fmod_top (
    input  wire         clk,
    input  wire         rst_n,
    dfm_req_if.sink     req,
    dfm_rsp_if.source   rsp
);
    dfm_pkg::state_t state_reg, state_next;

    logic [31:0]               xb_reg, xb_next;
    logic [dfm_pkg::CoefW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [7:0]                ex_reg, ex_next, ey_reg, ey_next;
    logic                      err_reg, err_next;
    logic [dfm_pkg::CoefW-1:0] a_reg, a_next, b_reg, b_next;
    logic [7:0]                ea_reg, ea_next, eb_reg, eb_next;
    logic [dfm_pkg::ModW-1:0]  m_reg, m_next, rem_reg, rem_next, acc_reg, acc_next;
    logic [7:0]                dcnt_reg, dcnt_next, oexp_reg, oexp_next;
    logic [4:0]                bit_reg, bit_next;
    logic [1:0]                phase_reg, phase_next;
    logic [dfm_pkg::BcdW-1:0]  bcd_reg, bcd_next;
    logic [31:0]               res_reg, res_next;
    logic                      rerr_reg, rerr_next;
    logic                      ovalid_reg, ovalid_next;
    logic [31:0]               obits_reg, obits_next;
    logic                      oerr_reg, oerr_next;

    dfm_pkg::unit_op_t         uop;
    logic [dfm_pkg::ModW-1:0]  ures;

    logic                      in_fire;
    logic [4:0]                cx_comb, cy_comb;
    logic [1:0]                msbx, msby;
    logic [3:0]                leadx, leady;
    logic                      badx, bady;
    logic [dfm_pkg::CoefW-1:0] cx_in, cy_in;
    logic [8:0]                ax, ay;
    logic [dfm_pkg::ModW-1:0]  a10, b10, m10;
    logic [dfm_pkg::BcdW-1:0]  bcd_adj;

    dfm_mod_unit u_mod (
        .op  (uop),
        .res (ures)
    );

    assign in_fire   = req.valid && req.ready;
    assign req.ready = (state_reg == dfm_pkg::S_IDLE);

    assign rsp.valid          = ovalid_reg;
    assign rsp.remainder_bits = obits_reg;
    assign rsp.domain_error   = oerr_reg;

    // operand unpacking
    always_comb
    begin
        cx_comb = req.dividend_bits[30:26];
        cy_comb = req.divisor_bits[30:26];
        badx = (cx_comb[4:3] == 2'b11) && (cx_comb[2:1] == 2'b11);
        bady = (cy_comb[4:3] == 2'b11) && (cy_comb[2:1] == 2'b11);
        if (cx_comb[4:3] != 2'b11)
        begin
            msbx = cx_comb[4:3]; leadx = {1'b0, cx_comb[2:0]};
        end
        else
        begin
            msbx = cx_comb[2:1]; leadx = {3'b100, cx_comb[0]};
        end
        if (cy_comb[4:3] != 2'b11)
        begin
            msby = cy_comb[4:3]; leady = {1'b0, cy_comb[2:0]};
        end
        else
        begin
            msby = cy_comb[2:1]; leady = {3'b100, cy_comb[0]};
        end
        cx_in = 24'(leadx) * 24'd1000000
              + 24'(dfm_pkg::bcd3_to_bin(dfm_pkg::dpd_decode(req.dividend_bits[19:10])))
                * 24'd1000
              + 24'(dfm_pkg::bcd3_to_bin(dfm_pkg::dpd_decode(req.dividend_bits[9:0])));
        cy_in = 24'(leady) * 24'd1000000
              + 24'(dfm_pkg::bcd3_to_bin(dfm_pkg::dpd_decode(req.divisor_bits[19:10])))
                * 24'd1000
              + 24'(dfm_pkg::bcd3_to_bin(dfm_pkg::dpd_decode(req.divisor_bits[9:0])));
    end

    always_comb
    begin
        ax  = {1'b0, ex_reg} + 9'(dfm_pkg::digit_count(cx_reg));
        ay  = {1'b0, ey_reg} + 9'(dfm_pkg::digit_count(cy_reg));
        a10 = {a_reg, 3'b000} + {2'b00, a_reg, 1'b0};
        b10 = {b_reg, 3'b000} + {2'b00, b_reg, 1'b0};
        m10 = {m_reg[23:0], 3'b000} + {m_reg[25:0], 1'b0};
        for (int i = 0; i < 7; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                            : bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        uop.opa     = rem_reg;
        uop.opb     = rem_reg;
        uop.cin     = 1'b0;
        uop.modulus = m_reg;
        if (state_reg == dfm_pkg::S_MODX)
        begin
            uop.cin = cx_reg[bit_reg];
        end
        else if (state_reg == dfm_pkg::S_DIGIT)
        begin
            case (phase_reg)
                2'd0:
                begin
                    uop.opa = rem_reg; uop.opb = rem_reg;
                end
                2'd2:
                begin
                    uop.opa = acc_reg; uop.opb = rem_reg;
                end
                default:
                begin
                    uop.opa = acc_reg; uop.opb = acc_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        xb_next = xb_reg; cx_next = cx_reg; cy_next = cy_reg;
        ex_next = ex_reg; ey_next = ey_reg; err_next = err_reg;
        a_next = a_reg; b_next = b_reg; ea_next = ea_reg; eb_next = eb_reg;
        m_next = m_reg; rem_next = rem_reg; acc_next = acc_reg;
        dcnt_next = dcnt_reg; oexp_next = oexp_reg; bit_next = bit_reg;
        phase_next = phase_reg; bcd_next = bcd_reg;
        res_next = res_reg; rerr_next = rerr_reg;
        ovalid_next = ovalid_reg; obits_next = obits_reg; oerr_next = oerr_reg;

        if (ovalid_reg && rsp.ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            dfm_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    xb_next  = req.dividend_bits;
                    cx_next  = cx_in;
                    cy_next  = cy_in;
                    ex_next  = {msbx, req.dividend_bits[25:20]};
                    ey_next  = {msby, req.divisor_bits[25:20]};
                    err_next = badx || bady || (cy_in == '0);
                    state_next = dfm_pkg::S_CHECK;
                end
            end
            dfm_pkg::S_CHECK:
            begin
                rerr_next = 1'b0;
                a_next = cx_reg; b_next = cy_reg; ea_next = ex_reg; eb_next = ey_reg;
                m_next = {3'b000, cy_reg};
                rem_next = '0;
                bit_next = 5'(dfm_pkg::CoefW - 1);
                if (err_reg)
                begin
                    res_next = dfm_pkg::QNAN_BITS; rerr_next = 1'b1;
                    state_next = dfm_pkg::S_FINISH;
                end
                else if (cx_reg == '0 || ax < ay)
                begin
                    res_next = xb_reg;
                    state_next = dfm_pkg::S_FINISH;
                end
                else if (ax == ay)
                begin
                    state_next = dfm_pkg::S_ALIGN;
                end
                else if (ex_reg >= ey_reg)
                begin
                    dcnt_next = ex_reg - ey_reg; oexp_next = ey_reg;
                    state_next = dfm_pkg::S_MODX;
                end
                else
                begin
                    dcnt_next = ey_reg - ex_reg; oexp_next = ex_reg;
                    state_next = dfm_pkg::S_SCALE;
                end
            end
            dfm_pkg::S_ALIGN:
            begin
                if (ea_reg > eb_reg)
                begin
                    a_next = a10[dfm_pkg::CoefW-1:0]; ea_next = ea_reg - 8'd1;
                end
                else if (eb_reg > ea_reg)
                begin
                    b_next = b10[dfm_pkg::CoefW-1:0]; eb_next = eb_reg - 8'd1;
                end
                else if (a_reg < b_reg)
                begin
                    res_next = xb_reg;
                    state_next = dfm_pkg::S_FINISH;
                end
                else if (a_reg == b_reg)
                begin
                    res_next = dfm_pkg::pack(xb_reg[31], '0, dfm_pkg::EXP_BIAS);
                    state_next = dfm_pkg::S_FINISH;
                end
                else if (ex_reg >= ey_reg)
                begin
                    dcnt_next = ex_reg - ey_reg; oexp_next = ey_reg;
                    state_next = dfm_pkg::S_MODX;
                end
                else
                begin
                    dcnt_next = ey_reg - ex_reg; oexp_next = ex_reg;
                    state_next = dfm_pkg::S_SCALE;
                end
            end
            dfm_pkg::S_SCALE:
            begin
                if (dcnt_reg != '0 && m_reg <= {3'b000, cx_reg})
                begin
                    m_next = m10; dcnt_next = dcnt_reg - 8'd1;
                end
                else
                begin
                    dcnt_next = '0;
                    state_next = dfm_pkg::S_MODX;
                end
            end
            dfm_pkg::S_MODX:
            begin
                rem_next = ures;
                bit_next = bit_reg - 5'd1;
                phase_next = '0;
                if (bit_reg == '0)
                begin
                    bit_next = 5'(dfm_pkg::CoefW - 1);
                    bcd_next = '0;
                    state_next = (dcnt_reg != '0) ? dfm_pkg::S_DIGIT : dfm_pkg::S_CONV;
                end
            end
            dfm_pkg::S_DIGIT:
            begin
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    rem_next = ures;
                    dcnt_next = dcnt_reg - 8'd1;
                    if (dcnt_reg == 8'd1)
                        state_next = dfm_pkg::S_CONV;
                end
                else
                begin
                    acc_next = ures;
                end
            end
            dfm_pkg::S_CONV:
            begin
                bcd_next = {bcd_adj[dfm_pkg::BcdW-2:0], rem_reg[dfm_pkg::CoefW-1]};
                rem_next = {rem_reg[dfm_pkg::ModW-2:0], 1'b0};
                bit_next = bit_reg - 5'd1;
                if (bit_reg == '0)
                begin
                    res_next = dfm_pkg::pack(xb_reg[31], bcd_next, oexp_reg);
                    state_next = dfm_pkg::S_FINISH;
                end
            end
            dfm_pkg::S_FINISH:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    obits_next  = res_reg;
                    oerr_next   = rerr_reg;
                    state_next  = dfm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dfm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dfm_pkg::S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xb_reg <= xb_next; cx_reg <= cx_next; cy_reg <= cy_next;
        ex_reg <= ex_next; ey_reg <= ey_next; err_reg <= err_next;
        a_reg <= a_next; b_reg <= b_next; ea_reg <= ea_next; eb_reg <= eb_next;
        m_reg <= m_next; rem_reg <= rem_next; acc_reg <= acc_next;
        dcnt_reg <= dcnt_next; oexp_reg <= oexp_next; bit_reg <= bit_next;
        phase_reg <= phase_next; bcd_reg <= bcd_next;
        res_reg <= res_next; rerr_reg <= rerr_next;
        obits_reg <= obits_next; oerr_reg <= oerr_next;
    end

`ifndef SYNTHESIS
    a_nan_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && oerr_reg) |-> (obits_reg == dfm_pkg::QNAN_BITS))
        else $error("domain error without quiet nan");

    a_request_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == dfm_pkg::S_CHECK))
        else $error("request not followed by check");

    a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dfm_pkg::S_DIGIT) |-> (rem_reg < m_reg))
        else $error("partial remainder not reduced");
`endif

endmodule
`default_nettype wire
